@@ hdl/aslp_pkg.sv @@
// Shared constants, types and helpers of the adaptive-step LMS predictor.
package aslp_pkg;

  localparam int TAPS   = 3;
  localparam int NCFG_W = 3;
  localparam int JW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FW     = $clog2(TAPS + 1);

  // Multiplier datapath: accumulator and multiplicand width, multiplier width
  localparam int AW  = 68;
  localparam int BW  = 28;
  localparam int DIG = 4;

  // Divider: quotient bits and remainder width
  localparam int QW = 17;
  localparam int RW = 42;
  localparam int DW = 41;

  typedef struct packed {
    logic       start;
    logic       load;
    logic [2:0] nd;
  } aslp_mul_ctrl_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_W0   = 3'd0;
  localparam logic [2:0] CFG_W1   = 3'd1;
  localparam logic [2:0] CFG_W2   = 3'd2;
  localparam logic [2:0] CFG_THR  = 3'd3;
  localparam logic [2:0] CFG_RATE = 3'd4;

  // Commands
  localparam logic [1:0] CMD_TRAIN   = 2'd0;
  localparam logic [1:0] CMD_EVAL    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic signed [AW-1:0] W24_HI = AW'(24'sh7FFFFF);
  localparam logic signed [AW-1:0] W24_LO = AW'(24'sh800000);
  localparam logic [39:0]          ENERGY_MAX = 40'hFF_FFFF_FFFF;

  // Clamp a wide signed value to 24 bits signed
  function automatic logic signed [23:0] sat24(input logic signed [AW-1:0] v);
    logic signed [23:0] r;
    if (v > W24_HI) begin
      r = 24'sh7FFFFF;
    end else if (v < W24_LO) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/aslp_digit_mul.sv @@
// Radix-16 digit-serial signed multiply-accumulate unit.
module aslp_digit_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aslp_pkg::aslp_mul_ctrl_t      ctrl_i,
  input  logic signed [aslp_pkg::AW-1:0] a_i,
  input  logic signed [aslp_pkg::BW-1:0] b_i,
  input  logic signed [aslp_pkg::AW-1:0] init_i,
  output logic                          done_o,
  output logic signed [aslp_pkg::AW-1:0] acc_o
);
  import aslp_pkg::*;

  logic signed [AW-1:0] a_q, a_d;
  logic signed [BW-1:0] b_q, b_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic [2:0]           cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic signed [4:0]    dig;
  logic signed [AW+4:0] prod;

  // Take one digit of the multiplier per cycle, the top digit signed
  always_comb begin
    dig  = (cnt_q == 3'd1) ? {b_q[DIG-1], b_q[DIG-1:0]} : {1'b0, b_q[DIG-1:0]};
    prod = a_q * dig;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      a_d   = a_i;
      b_d   = b_i;
      cnt_d = ctrl_i.nd;
      acc_d = ctrl_i.load ? init_i : acc_q;
    end else if (cnt_q != 3'd0) begin
      acc_d  = acc_q + prod[AW-1:0];
      a_d    = a_q <<< DIG;
      b_d    = b_q >>> DIG;
      cnt_d  = cnt_q - 3'd1;
      done_d = (cnt_q == 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

@@ hdl/aslp_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the rate reciprocal.
module aslp_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [aslp_pkg::RW-1:0]  num_i,
  input  logic [aslp_pkg::DW-1:0]  den_i,
  output logic                     done_o,
  output logic [aslp_pkg::QW-1:0]  quot_o
);
  import aslp_pkg::*;

  localparam int SW = DW + QW - 1;
  localparam int CW = $clog2(QW + 1);

  logic [RW-1:0] r_q, r_d;
  logic [SW-1:0] d_q, d_d;
  logic [QW-1:0] q_q, q_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic          ge;

  // Compare, subtract and shift the divisor down one place per cycle
  always_comb begin
    ge     = {{(SW-RW){1'b0}}, r_q} >= d_q;
    r_d    = r_q;
    d_d    = d_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d   = num_i;
      d_d   = {den_i, {(QW-1){1'b0}}};
      q_d   = '0;
      cnt_d = CW'(QW);
    end else if (cnt_q != '0) begin
      if (ge) begin
        r_d = r_q - d_q[RW-1:0];
      end
      q_d    = {q_q[QW-2:0], ge};
      d_d    = d_q >> 1;
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    d_q <= d_d;
    q_q <= q_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

@@ hdl/adaptive_step_lms_predictor_core.sv @@
// Top level of the adaptive-step LMS linear predictor.
//
// Input channel (in_valid_i/in_ready_o) takes one word: command, start-of-pass
// flag and a Q3.12 sample. Output channel (out_valid_o/out_ready_i) returns
// one word per input word: prediction_valid, prediction (Q7.16) and half the
// squared error (Q8.24). The configuration port writes start weights,
// threshold and rate by index with no wait.
// One word is processed at a time. All products run through one radix-16
// digit-serial multiplier and the new rate comes from a one-bit-per-cycle
// divider. in_ready_o is high while idle, also while a finished word still
// waits on the output register.
// Reset clears the window, fill count and energy sum, loads the register
// reset values into weights, threshold and rate, and empties the output.
// While the receiver stalls the output word holds and the next input word
// is taken and processed; its result waits until the output register frees.
module adaptive_step_lms_predictor_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic               start_of_pass_i,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               prediction_valid_o,
  output logic signed [23:0] prediction_o,
  output logic [31:0]        half_square_error_o
);
  import aslp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DOT  = 8'b0000_0010,
    S_SQR  = 8'b0000_0100,
    S_ENG  = 8'b0000_1000,
    S_RERR = 8'b0001_0000,
    S_WUPD = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } aslp_state_e;

  localparam logic signed [AW-1:0] RND9  = AW'(256);
  localparam logic signed [AW-1:0] RND12 = AW'(2048);
  localparam logic signed [AW-1:0] RND16 = AW'(32768);
  localparam logic signed [AW-1:0] RND28 = AW'(134217728);

  aslp_state_e state_q, state_d;
  logic        go_q, go_d;
  logic [JW-1:0] j_q, j_d;

  logic signed [23:0] cfg_w_q [NCFG_W];
  logic signed [23:0] cfg_thr_q;
  logic [15:0]        cfg_rate_q;

  logic signed [15:0] win_q [TAPS];
  logic signed [15:0] win_d [TAPS];
  logic signed [23:0] w_q   [TAPS];
  logic signed [23:0] w_d   [TAPS];
  logic [FW-1:0]      fill_q, fill_d;
  logic signed [23:0] thr_q, thr_d;
  logic [15:0]        rate_q, rate_d;
  logic [39:0]        energy_q, energy_d;

  logic [1:0]         cmd_q, cmd_d;
  logic signed [15:0] x_q, x_d;
  logic signed [25:0] err_q, err_d;
  logic signed [41:0] re_q, re_d;

  logic               res_pv_q, res_pv_d;
  logic signed [23:0] res_y_q, res_y_d;
  logic [31:0]        res_sq_q, res_sq_d;

  logic               out_valid_q, out_valid_d;
  logic               out_pv_q, out_pv_d;
  logic signed [23:0] out_y_q, out_y_d;
  logic [31:0]        out_sq_q, out_sq_d;

  aslp_mul_ctrl_t       mul_ctrl;
  logic signed [AW-1:0] mul_a, mul_init, mul_acc;
  logic signed [BW-1:0] mul_b;
  logic                 mul_done;

  logic            div_start, div_done;
  logic [DW-1:0]   div_den;
  logic [RW-1:0]   div_num;
  logic [QW-1:0]   div_quot;

  logic signed [25:0] mag_s;
  logic [24:0]        mag;

  // Shared units
  aslp_digit_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .init_i (mul_init),
    .done_o (mul_done),
    .acc_o  (mul_acc)
  );

  aslp_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Form divider operands from the energy sum
  assign div_den = {1'b0, energy_q} + (DW'(1) << 24);
  assign div_num = (RW'(1) << 40) + {2'b00, div_den[DW-1:1]};

  // Pick multiplier operands for the current step
  always_comb begin
    mag_s = err_q[25] ? -err_q : err_q;
    mag   = mag_s[24:0];
    mul_ctrl.start = go_q && (state_q != S_DIV) && (state_q != S_IDLE)
                     && (state_q != S_OUT);
    mul_ctrl.load  = 1'b1;
    mul_ctrl.nd    = 3'd4;
    mul_a    = '0;
    mul_b    = '0;
    mul_init = '0;
    unique case (state_q)
      S_DOT: begin
        mul_a = AW'(w_q[j_q]);
        mul_b = BW'(win_q[j_q]);
        mul_ctrl.load = (j_q == '0);
        mul_init = -($signed({{(AW-24){thr_q[23]}}, thr_q}) <<< 12);
      end
      S_SQR: begin
        mul_a = AW'($signed({1'b0, mag}));
        mul_b = BW'($signed({1'b0, mag}));
        mul_ctrl.nd = 3'd7;
      end
      S_ENG: begin
        mul_a = AW'(win_q[j_q]);
        mul_b = BW'(win_q[j_q]);
      end
      S_RERR: begin
        mul_a = AW'(err_q);
        mul_b = BW'($signed({1'b0, rate_q}));
        mul_ctrl.nd = 3'd5;
      end
      S_WUPD: begin
        mul_a = AW'(re_q);
        mul_b = BW'(win_q[j_q]);
      end
      S_IDLE, S_DIV, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign div_start = go_q && (state_q == S_DIV);

  // Sequence one word
  always_comb begin
    logic               shift_c;
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] tsh;
    logic signed [23:0] y_c;
    logic [40:0]        esum;
    logic [FW-1:0]      fill_e;

    shift_c     = 1'b0;
    t           = '0;
    tsh         = '0;
    y_c         = '0;
    esum        = '0;
    fill_e      = fill_q;
    state_d     = state_q;
    go_d        = 1'b0;
    j_d         = j_q;
    win_d       = win_q;
    w_d         = w_q;
    fill_d      = fill_q;
    thr_d       = thr_q;
    rate_d      = rate_q;
    energy_d    = energy_q;
    cmd_d       = cmd_q;
    x_d         = x_q;
    err_d       = err_q;
    re_d        = re_q;
    res_pv_d    = res_pv_q;
    res_y_d     = res_y_q;
    res_sq_d    = res_sq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pv_d    = out_pv_q;
    out_y_d     = out_y_q;
    out_sq_d    = out_sq_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = command_i;
          x_d      = sample_i;
          res_pv_d = 1'b0;
          res_y_d  = '0;
          res_sq_d = '0;
          state_d  = S_OUT;
          if (start_of_pass_i) begin
            for (int k = 0; k < TAPS; k++) begin
              win_d[k] = '0;
            end
            fill_e   = '0;
            fill_d   = '0;
            energy_d = '0;
          end
          unique case (command_i)
            CMD_RESTART: begin
              for (int k = 0; k < TAPS; k++) begin
                w_d[k] = '0;
                if (k < NCFG_W) begin
                  w_d[k] = cfg_w_q[k];
                end
              end
              thr_d  = cfg_thr_q;
              rate_d = cfg_rate_q;
            end
            CMD_TRAIN, CMD_EVAL: begin
              if (fill_e < FW'(TAPS)) begin
                for (int k = 0; k + 1 < TAPS; k++) begin
                  win_d[k] = win_d[k+1];
                end
                win_d[TAPS-1] = sample_i;
                fill_d = fill_e + FW'(1);
              end else begin
                state_d = S_DOT;
                go_d    = 1'b1;
                j_d     = '0;
              end
            end
            CMD_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_DOT: begin
        if (mul_done) begin
          if (j_q != JW'(TAPS - 1)) begin
            j_d  = j_q + JW'(1);
            go_d = 1'b1;
          end else begin
            t   = mul_acc + RND12;
            y_c = sat24(t >>> 12);
            err_d = $signed({{2{y_c[23]}}, y_c}) - $signed({{6{x_q[15]}}, x_q, 4'b0000});
            res_y_d  = y_c;
            res_pv_d = 1'b1;
            state_d  = S_SQR;
            go_d     = 1'b1;
          end
        end
      end
      S_SQR: begin
        if (mul_done) begin
          t   = mul_acc + RND9;
          tsh = t >>> 9;
          res_sq_d = (|tsh[AW-1:32]) ? 32'hFFFF_FFFF : tsh[31:0];
          if (cmd_q == CMD_TRAIN) begin
            state_d = S_ENG;
            j_d     = '0;
            go_d    = 1'b1;
          end else begin
            shift_c = 1'b1;
            state_d = S_OUT;
          end
        end
      end
      S_ENG: begin
        if (mul_done) begin
          esum = {1'b0, energy_q} + {1'b0, mul_acc[39:0]};
          energy_d = esum[40] ? ENERGY_MAX : esum[39:0];
          go_d = 1'b1;
          if (j_q != JW'(TAPS - 1)) begin
            j_d = j_q + JW'(1);
          end else begin
            state_d = S_RERR;
          end
        end
      end
      S_RERR: begin
        if (mul_done) begin
          re_d  = mul_acc[41:0];
          t     = mul_acc + RND16;
          thr_d = sat24($signed({{(AW-24){thr_q[23]}}, thr_q}) + (t >>> 16));
          state_d = S_WUPD;
          j_d     = '0;
          go_d    = 1'b1;
        end
      end
      S_WUPD: begin
        if (mul_done) begin
          t = mul_acc + RND28;
          w_d[j_q] = sat24($signed({{(AW-24){w_q[j_q][23]}}, w_q[j_q]}) - (t >>> 28));
          go_d = 1'b1;
          if (j_q != JW'(TAPS - 1)) begin
            j_d = j_q + JW'(1);
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          rate_d  = div_quot[QW-1] ? 16'hFFFF : div_quot[15:0];
          shift_c = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_pv_d    = res_pv_q;
          out_y_d     = res_y_q;
          out_sq_d    = res_sq_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Advance the window after a full prediction
    if (shift_c) begin
      for (int k = 0; k + 1 < TAPS; k++) begin
        win_d[k] = win_q[k+1];
      end
      win_d[TAPS-1] = x_q;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      energy_q    <= '0;
      thr_q       <= 24'sd32768;
      rate_q      <= 16'd6554;
      cfg_thr_q   <= 24'sd32768;
      cfg_rate_q  <= 16'd6554;
      for (int k = 0; k < TAPS; k++) begin
        win_q[k] <= '0;
        w_q[k]   <= (k < NCFG_W) ? 24'sd32768 : 24'sd0;
      end
      for (int k = 0; k < NCFG_W; k++) begin
        cfg_w_q[k] <= 24'sd32768;
      end
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
      energy_q    <= energy_d;
      thr_q       <= thr_d;
      rate_q      <= rate_d;
      win_q       <= win_d;
      w_q         <= w_d;
      // Write configuration registers; drop unknown indexes
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_W0:   cfg_w_q[0] <= cfg_data_i;
          CFG_W1:   cfg_w_q[1] <= cfg_data_i;
          CFG_W2:   cfg_w_q[2] <= cfg_data_i;
          CFG_THR:  cfg_thr_q  <= cfg_data_i;
          CFG_RATE: cfg_rate_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    j_q      <= j_d;
    cmd_q    <= cmd_d;
    x_q      <= x_d;
    err_q    <= err_d;
    re_q     <= re_d;
    res_pv_q <= res_pv_d;
    res_y_q  <= res_y_d;
    res_sq_q <= res_sq_d;
    out_pv_q <= out_pv_d;
    out_y_q  <= out_y_d;
    out_sq_q <= out_sq_d;
  end

  assign in_ready_o          = (state_q == S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign prediction_valid_o  = out_pv_q;
  assign prediction_o        = out_y_q;
  assign half_square_error_o = out_sq_q;

endmodule

@@ hdl/aslp_checker.sv @@
// Port-level checks of the predictor, bound to the top level.
module aslp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [2:0]         cfg_index_i,
  input logic [23:0]        cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         command_i,
  input logic               start_of_pass_i,
  input logic signed [15:0] sample_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               prediction_valid_o,
  input logic signed [23:0] prediction_o,
  input logic [31:0]        half_square_error_o
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(prediction_o)
      && $stable(half_square_error_o) && $stable(prediction_valid_o))
    else $error("output word changed while stalled");

  // An invalid prediction carries zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !prediction_valid_o |-> prediction_o == 24'sd0
      && half_square_error_o == 32'd0)
    else $error("invalid prediction with nonzero fields");

  // One word in flight: ready drops after every accepted word
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");

endmodule

bind adaptive_step_lms_predictor_core aslp_checker u_aslp_checker (.*);

@@ tb/adaptive_step_lms_predictor_core_tb.sv @@
// Self-checking testbench of the adaptive-step LMS predictor core.
`timescale 1ns / 100ps

module adaptive_step_lms_predictor_core_tb;
  import aslp_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [23:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         command_i;
  logic               start_of_pass_i;
  logic signed [15:0] sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               prediction_valid_o;
  logic signed [23:0] prediction_o;
  logic [31:0]        half_square_error_o;

  typedef struct packed {
    logic        pvalid;
    logic [23:0] pred;
    logic [31:0] hse;
  } pred_word_t;

  // Predictor state and configuration copies
  logic signed [23:0] start_weight [3];
  logic signed [23:0] start_thr;
  logic [15:0]        start_rate;
  logic signed [15:0] window [3];
  int                 fill;
  logic signed [23:0] weight [3];
  logic signed [23:0] thr;
  logic [15:0]        rate;
  logic [39:0]        energy;

  pred_word_t expected_q[$];
  int         errors;
  int         n_results;
  bit         quiet;
  bit         out_stall_en;

  adaptive_step_lms_predictor_core i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // Round to nearest with ties toward +inf, arithmetic shift is floor
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  task automatic reload_start;
    for (int j = 0; j < 3; j++) weight[j] = start_weight[j];
    thr = start_thr;
    rate = start_rate;
  endtask

  // Compute the result word of one input word and advance the state
  function automatic pred_word_t predict_word(input logic [1:0] cmd, input logic sop,
                                              input logic signed [15:0] smp);
    pred_word_t r;
    longint acc, y, err, sq, p;
    longint unsigned mag, en, den, q;
    r = '0;
    if (sop) begin
      for (int j = 0; j < 3; j++) window[j] = '0;
      fill = 0;
      energy = '0;
    end
    if (cmd == CMD_RESTART) begin
      for (int j = 0; j < 3; j++) weight[j] = start_weight[j];
      thr = start_thr;
      rate = start_rate;
      return r;
    end
    if (cmd == CMD_NOP) return r;
    if (fill >= 3) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += longint'(weight[j]) * longint'(window[j]);
      acc -= longint'(thr) * 4096;
      y = clamp24(rnd_shift(acc, 12));
      err = y - longint'(smp) * 16;
      mag = (err < 0) ? -err : err;
      sq = (mag * mag + 256) >> 9;
      r.pvalid = 1'b1;
      r.pred = y[23:0];
      r.hse = (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
      if (cmd == CMD_TRAIN) begin
        en = energy;
        for (int j = 0; j < 3; j++) begin
          mag = (window[j] < 0) ? -longint'(window[j]) : longint'(window[j]);
          en += mag * mag;
          if (en > 64'hFF_FFFF_FFFF) en = 64'hFF_FFFF_FFFF;
        end
        energy = en[39:0];
        for (int j = 0; j < 3; j++) begin
          p = longint'(rate) * err * longint'(window[j]);
          weight[j] = clamp24(longint'(weight[j]) - rnd_shift(p, 28));
        end
        thr = clamp24(longint'(thr) + rnd_shift(longint'(rate) * err, 16));
        den = en + (64'd1 << 24);
        q = ((64'd1 << 40) + den / 2) / den;
        rate = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
      end
    end
    window[0] = window[1];
    window[1] = window[2];
    window[2] = smp;
    if (fill < 3) fill++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp, n_results);
  endtask

  // Check each accepted result word against the oldest expectation
  always @(posedge clk_i) begin
    pred_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = expected_q.pop_front();
        if (prediction_valid_o !== e.pvalid)
          report_mismatch("prediction_valid", longint'(prediction_valid_o),
                          longint'(e.pvalid));
        if (prediction_o !== e.pred)
          report_mismatch("prediction", longint'(prediction_o),
                          longint'($signed(e.pred)));
        if (half_square_error_o !== e.hse)
          report_mismatch("half_square_error", longint'(half_square_error_o),
                          longint'(e.hse));
      end
      n_results++;
    end
  end

  // Receiver stalls in random bursts
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (out_stall_en && !quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Send one word and predict its result; valid drops only in an idle gap
  task automatic send_word(input logic [1:0] cmd, input logic sop,
                           input logic signed [15:0] smp);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    start_of_pass_i <= sop;
    sample_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_word(cmd, sop, smp));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Write one register; the caller drops the write enable after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_W0, CFG_W1, CFG_W2: start_weight[idx] = val;
      CFG_THR: start_thr = val;
      CFG_RATE: start_rate = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [23:0] w0, input logic [23:0] w1,
                           input logic [23:0] w2, input logic [23:0] t,
                           input logic [15:0] r);
    write_reg(CFG_W0, w0);
    write_reg(CFG_W1, w1);
    write_reg(CFG_W2, w2);
    write_reg(CFG_THR, t);
    write_reg(CFG_RATE, {8'd0, r});
  endtask

  function automatic logic signed [15:0] rand_sample;
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom());
    endcase
  endfunction

  // Directed: extremes of samples, every command and special case
  task automatic test_directed;
    send_word(CMD_TRAIN, 1'b1, 16'sh7FFF);
    send_word(CMD_EVAL, 1'b0, 16'sh8000);
    send_word(CMD_TRAIN, 1'b0, 16'sh7FFF);
    send_word(CMD_EVAL, 1'b0, 16'sh8000);
    send_word(CMD_TRAIN, 1'b0, 16'sh7FFF);
    send_word(CMD_TRAIN, 1'b0, 16'sh0000);
    send_word(CMD_NOP, 1'b0, 16'sh1234);
    send_word(CMD_TRAIN, 1'b0, -16'sd1);
    send_word(CMD_RESTART, 1'b0, 16'sh5555);
    send_word(CMD_EVAL, 1'b0, 16'sh1000);
    send_word(CMD_NOP, 1'b1, 16'sh2AAA);
    send_word(CMD_EVAL, 1'b0, 16'sh1000);
    send_word(CMD_RESTART, 1'b1, 16'sh0);
    for (int i = 0; i < 6; i++) send_word(CMD_TRAIN, 1'b0, (i & 1) ? 16'sh8000 : 16'sh7FFF);
  endtask

  // Well-formed passes with random content and some noise
  task automatic test_random(input int count);
    int left;
    left = count;
    while (left > 0) begin
      int len;
      send_word(CMD_RESTART, 1'($urandom_range(0, 1)), 16'($urandom()));
      send_word(CMD_TRAIN, 1'b1, rand_sample());
      len = $urandom_range(4, 30);
      for (int i = 0; i < len && left > 0; i++, left--) begin
        case ($urandom_range(0, 19))
          0: send_word(CMD_NOP, 1'($urandom_range(0, 1)), 16'($urandom()));
          1: send_word(CMD_RESTART, 1'b0, 16'($urandom()));
          2, 3, 4: send_word(CMD_EVAL, $urandom_range(0, 15) == 0, rand_sample());
          default: send_word(CMD_TRAIN, $urandom_range(0, 31) == 0, rand_sample());
        endcase
      end
    end
  endtask

  initial begin
    errors = 0;
    n_results = 0;
    quiet = 1'b0;
    out_stall_en = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_W0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_NOP;
    start_of_pass_i = 1'b0;
    sample_i = '0;
    for (int j = 0; j < 3; j++) begin
      window[j] = '0;
      start_weight[j] = 24'sd32768;
    end
    start_thr = 24'sd32768;
    start_rate = 16'd6554;
    fill = 0;
    energy = '0;
    reload_start();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    drain();
    write_all(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 16'hFFFF);
    write_reg(3'd7, 24'h123456);
    cfg_we_i <= 1'b0;
    test_directed();
    drain();
    write_all(24'h000000, 24'h000000, 24'h000000, 24'h000000, 16'h0000);
    cfg_we_i <= 1'b0;
    test_random(280);
    drain();
    write_all(24'h00C000, 24'hFFA000, 24'h010000, 24'h000800, 16'h2000);
    cfg_we_i <= 1'b0;
    test_random(450);
    drain();
    write_all(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
              16'($urandom()));
    cfg_we_i <= 1'b0;
    test_random(370);
    drain();
    write_all(24'h008000, 24'h008000, 24'h008000, 24'h008000, 16'd6554);
    cfg_we_i <= 1'b0;
    quiet = 1'b1;
    out_stall_en = 1'b0;
    test_random(400);
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/aslp_pkg.sv
hdl/aslp_digit_mul.sv
hdl/aslp_divider.sv
hdl/adaptive_step_lms_predictor_core.sv
hdl/aslp_checker.sv
tb/adaptive_step_lms_predictor_core_tb.sv
